[sv/cfsh_pkg.sv]
// Package for the class file header scanner.
// Holds pool tag codes, field byte counts, parse phases and the result struct.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package cfsh_pkg;

  // Default width of the byte position counter.
  localparam int POSITION_BITS_DEF = 32;

  // Constant-pool tag codes.
  localparam logic [7:0] TAG_UTF8       = 8'd1;
  localparam logic [7:0] TAG_INTEGER    = 8'd3;
  localparam logic [7:0] TAG_FLOAT      = 8'd4;
  localparam logic [7:0] TAG_LONG       = 8'd5;
  localparam logic [7:0] TAG_DOUBLE     = 8'd6;
  localparam logic [7:0] TAG_CLASS      = 8'd7;
  localparam logic [7:0] TAG_STRING     = 8'd8;
  localparam logic [7:0] TAG_FIELDREF   = 8'd9;
  localparam logic [7:0] TAG_METHODREF  = 8'd10;
  localparam logic [7:0] TAG_IMETHODREF = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE   = 8'd12;

  // Payload bytes skipped after a tag.
  localparam logic [15:0] SKIP_WIDE = 16'd8;
  localparam logic [15:0] SKIP_WORD = 16'd4;
  localparam logic [15:0] SKIP_HALF = 16'd2;

  // Pool slots taken by an entry.
  localparam logic [15:0] SLOTS_WIDE   = 16'd2;
  localparam logic [15:0] SLOTS_SINGLE = 16'd1;

  // Byte counts of the fixed-size fields.
  localparam logic [3:0] HEADER_BYTES = 4'd10;
  localparam logic [3:0] UTFLEN_BYTES = 4'd2;
  localparam logic [3:0] CLASS_BYTES  = 4'd8;
  localparam logic [3:0] IFACE_BYTES  = 4'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADTAG = 2'd1;
  localparam logic [1:0] ST_SHORT  = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TAG,
    PH_UTFLEN,
    PH_PAYLOAD,
    PH_CLASS,
    PH_IFACE,
    PH_DONE,
    PH_FAILED
  } phase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } cfsh_result_t;

endpackage

`default_nettype wire

[sv/class_file_header_scanner.sv]
// Top level of the class file header scanner.
// Instantiates cfsh_parse and cfsh_out_reg; depends on cfsh_pkg.
`default_nettype none

// The scanner takes a class file one byte per transaction on the in_ stream,
// with in_tlast on the final byte, and sends one result transaction per file
// on the out_ stream: a status (ok, unknown constant tag, or file too short),
// the byte offset just after the interface table and the number of bytes that
// follow it, both zero unless the status is ok. Every byte is parsed in the
// cycle it is accepted, so the block takes one byte per clock, back to back,
// with no gap between files; the only thing that stalls the input is a result
// still held in the output register while out_tready is low, because the
// parse state updates in the same cycle as the accepted byte and the single
// result register is the only place a finished result can wait. A result
// appears in the cycle after its last byte. No clearing pass is needed after
// reset, and the parser returns to its start state by itself after each file.
module class_file_header_scanner #(
  parameter int POSITION_BITS = cfsh_pkg::POSITION_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream: one byte of the class file per transaction.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic        in_tlast,   // last_byte
  // Result stream: one transaction per file.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata   // [1:0] status, [33:2] data_offset,
                                       // [65:34] data_size, [71:66] zero
);

  logic                   in_accept;
  logic                   res_fire;
  cfsh_pkg::cfsh_result_t res;
  cfsh_pkg::cfsh_result_t held;
  logic                   held_full;

  // A new byte can enter whenever the result register is empty or draining.
  assign in_tready = !held_full || out_tready;
  assign in_accept = in_tvalid && in_tready;

  cfsh_parse #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_accept(in_accept),
    .byte_value (in_tdata),
    .last_byte  (in_tlast),
    .res_fire   (res_fire),
    .res        (res)
  );

  cfsh_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_fire),
    .load_data(res),
    .take     (out_tready),
    .full     (held_full),
    .data     (held)
  );

  assign out_tvalid = held_full;
  assign out_tdata  = {6'd0, held.data_size, held.data_offset, held.status};

endmodule

`default_nettype wire

[sv/cfsh_parse.sv]
// Byte-serial parse engine of the class file header scanner.
// Holds the phase, position and field counters and builds the result on the last byte.
// Depends on cfsh_pkg.
`default_nettype none

module cfsh_parse #(
  parameter int POSITION_BITS = cfsh_pkg::POSITION_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 byte_accept,
  input  wire logic [7:0]           byte_value,
  input  wire logic                 last_byte,
  output logic                      res_fire,
  output cfsh_pkg::cfsh_result_t    res
);

  localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  cfsh_pkg::phase_t          phase_r, phase_nxt;
  logic [POSITION_BITS-1:0]  pos_r, pos_nxt;
  logic [POSITION_BITS-1:0]  found_r, found_nxt;
  logic [3:0]                idx_r, idx_nxt;
  logic [15:0]               gather_r, gather_nxt;
  logic [15:0]               entries_r, entries_nxt;
  logic [15:0]               skip_r, skip_nxt;
  logic [1:0]                status_r, status_nxt;

  logic [15:0] shifted;
  logic [3:0]  idx_inc;
  logic [15:0] take_n;
  logic        take_en;
  logic        entry_end;
  logic [POSITION_BITS-1:0] size_full;

  always_comb begin
    shifted     = {gather_r[7:0], byte_value};
    idx_inc     = idx_r + 4'd1;
    pos_nxt     = pos_r + POS_ONE;
    phase_nxt   = phase_r;
    found_nxt   = found_r;
    idx_nxt     = idx_r;
    gather_nxt  = gather_r;
    entries_nxt = entries_r;
    skip_nxt    = skip_r;
    status_nxt  = status_r;
    take_n      = cfsh_pkg::SLOTS_SINGLE;
    take_en     = 1'b0;
    entry_end   = 1'b0;
    res_fire    = 1'b0;
    res         = '0;
    size_full   = '0;

    case (phase_r)
      cfsh_pkg::PH_HEADER: begin
        gather_nxt = shifted;
        idx_nxt    = idx_inc;
        if (idx_inc == cfsh_pkg::HEADER_BYTES) begin
          entries_nxt = (shifted != 16'd0) ? shifted - 16'd1 : 16'd0;
          idx_nxt     = 4'd0;
          entry_end   = 1'b1;
        end
      end
      cfsh_pkg::PH_TAG: begin
        case (byte_value)
          cfsh_pkg::TAG_LONG, cfsh_pkg::TAG_DOUBLE: begin
            take_en   = 1'b1;
            take_n    = cfsh_pkg::SLOTS_WIDE;
            skip_nxt  = cfsh_pkg::SKIP_WIDE;
            phase_nxt = cfsh_pkg::PH_PAYLOAD;
          end
          cfsh_pkg::TAG_INTEGER, cfsh_pkg::TAG_FLOAT, cfsh_pkg::TAG_FIELDREF,
          cfsh_pkg::TAG_METHODREF, cfsh_pkg::TAG_IMETHODREF,
          cfsh_pkg::TAG_NAMETYPE: begin
            take_en   = 1'b1;
            skip_nxt  = cfsh_pkg::SKIP_WORD;
            phase_nxt = cfsh_pkg::PH_PAYLOAD;
          end
          cfsh_pkg::TAG_CLASS, cfsh_pkg::TAG_STRING: begin
            take_en   = 1'b1;
            skip_nxt  = cfsh_pkg::SKIP_HALF;
            phase_nxt = cfsh_pkg::PH_PAYLOAD;
          end
          cfsh_pkg::TAG_UTF8: begin
            take_en   = 1'b1;
            idx_nxt   = 4'd0;
            phase_nxt = cfsh_pkg::PH_UTFLEN;
          end
          default: begin
            status_nxt = cfsh_pkg::ST_BADTAG;
            phase_nxt  = cfsh_pkg::PH_FAILED;
          end
        endcase
      end
      cfsh_pkg::PH_UTFLEN: begin
        gather_nxt = shifted;
        idx_nxt    = idx_inc;
        if (idx_inc == cfsh_pkg::UTFLEN_BYTES) begin
          idx_nxt = 4'd0;
          if (shifted == 16'd0) begin
            entry_end = 1'b1;
          end else begin
            skip_nxt  = shifted;
            phase_nxt = cfsh_pkg::PH_PAYLOAD;
          end
        end
      end
      cfsh_pkg::PH_PAYLOAD: begin
        skip_nxt = (skip_r != 16'd0) ? skip_r - 16'd1 : 16'd0;
        if (skip_nxt == 16'd0) begin
          entry_end = 1'b1;
        end
      end
      cfsh_pkg::PH_CLASS: begin
        gather_nxt = shifted;
        idx_nxt    = idx_inc;
        if (idx_inc == cfsh_pkg::CLASS_BYTES) begin
          idx_nxt     = 4'd0;
          entries_nxt = shifted;
          if (shifted == 16'd0) begin
            found_nxt = pos_nxt;
            phase_nxt = cfsh_pkg::PH_DONE;
          end else begin
            phase_nxt = cfsh_pkg::PH_IFACE;
          end
        end
      end
      cfsh_pkg::PH_IFACE: begin
        idx_nxt = idx_inc;
        if (idx_inc >= cfsh_pkg::IFACE_BYTES) begin
          idx_nxt     = 4'd0;
          entries_nxt = (entries_r > 16'd1) ? entries_r - 16'd1 : 16'd0;
          if (entries_r <= 16'd1) begin
            found_nxt = pos_nxt;
            phase_nxt = cfsh_pkg::PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase

    // A pool entry gives up its slots; a wide entry in the last slot takes it all.
    if (take_en) begin
      entries_nxt = (entries_r > take_n) ? entries_r - take_n : 16'd0;
    end

    if (entry_end) begin
      if (entries_nxt == 16'd0) begin
        phase_nxt = cfsh_pkg::PH_CLASS;
        idx_nxt   = 4'd0;
      end else begin
        phase_nxt = cfsh_pkg::PH_TAG;
      end
    end

    size_full = pos_nxt - found_nxt;

    if (last_byte) begin
      res_fire = byte_accept;
      if (phase_nxt == cfsh_pkg::PH_DONE) begin
        res.status      = cfsh_pkg::ST_OK;
        res.data_offset = 32'(found_nxt);
        res.data_size   = 32'(size_full);
      end else if (phase_nxt == cfsh_pkg::PH_FAILED) begin
        res.status = status_nxt;
      end else begin
        res.status = cfsh_pkg::ST_SHORT;
      end
      // Back to the reset state for the next file.
      phase_nxt   = cfsh_pkg::PH_HEADER;
      pos_nxt     = '0;
      found_nxt   = '0;
      idx_nxt     = 4'd0;
      gather_nxt  = 16'd0;
      entries_nxt = 16'd0;
      skip_nxt    = 16'd0;
      status_nxt  = cfsh_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= cfsh_pkg::PH_HEADER;
      pos_r     <= '0;
      found_r   <= '0;
      idx_r     <= 4'd0;
      gather_r  <= 16'd0;
      entries_r <= 16'd0;
      skip_r    <= 16'd0;
      status_r  <= cfsh_pkg::ST_OK;
    end else if (byte_accept) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      found_r   <= found_nxt;
      idx_r     <= idx_nxt;
      gather_r  <= gather_nxt;
      entries_r <= entries_nxt;
      skip_r    <= skip_nxt;
      status_r  <= status_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/cfsh_out_reg.sv]
// Result register of the class file header scanner.
// Holds one result transaction until the sink takes it; depends on cfsh_pkg.
`default_nettype none

module cfsh_out_reg (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire cfsh_pkg::cfsh_result_t load_data,
  input  wire logic                   take,
  output logic                        full,
  output cfsh_pkg::cfsh_result_t      data
);

  logic                   valid_r, valid_nxt;
  cfsh_pkg::cfsh_result_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign full = valid_r;
  assign data = data_r;

endmodule

`default_nettype wire

[sv/cfsh_checker.sv]
// Port-level checker for the class file header scanner, bound to the top level.
// Depends on cfsh_pkg and class_file_header_scanner.
`default_nettype none

module cfsh_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [71:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The final byte of a file always produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no result after the last byte");

  // A fresh result only follows an accepted final byte.
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast))
    else $error("result without a last byte");

  // Error results carry no offset and no size.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != cfsh_pkg::ST_OK |-> out_tdata[71:2] == 70'd0)
    else $error("error result with nonzero offset or size");

  // A held result that cannot drain blocks the input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while result register blocked");

endmodule

bind class_file_header_scanner cfsh_checker u_cfsh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tlast  (in_tlast),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire
